/* src/pttt_pkg.sv */
package pttt_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = 4;
    localparam int TICK_W     = 32;
    localparam int RUNS_W     = 16;
    localparam int REQ_W      = 4;
    localparam int ST_W       = 2;
    localparam int IN_TDATA_W = 128;
    localparam int OUT_TDATA_W = 48;

    localparam logic [RUNS_W-1:0] RUNS_FOREVER = '1;
    localparam logic [RUNS_W-1:0] RUNS_MAX     = 16'h7FFF;

    localparam logic [REQ_W-1:0] REQ_SERVICE   = 4'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE    = 4'd1;
    localparam logic [REQ_W-1:0] REQ_ALTER     = 4'd2;
    localparam logic [REQ_W-1:0] REQ_PERIOD    = 4'd3;
    localparam logic [REQ_W-1:0] REQ_RUNS      = 4'd4;
    localparam logic [REQ_W-1:0] REQ_AUTOCLEAR = 4'd5;
    localparam logic [REQ_W-1:0] REQ_ENABLE    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_DISABLE   = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DELAY     = 4'd8;
    localparam logic [REQ_W-1:0] REQ_FIRE      = 4'd9;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 4'd10;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 4'd11;
    localparam logic [REQ_W-1:0] REQ_RESTART   = 4'd12;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_COUNT,
        S_REPORT,
        S_EMIT,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic load;
        logic do_cmd;
        logic count;
        logic report;
        logic clr_idx;
        logic step_idx;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic is_service;
        logic zero_ticks;
        logic idx_last;
        logic hit;
        logic any_fired;
    } t_stat;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ST_W-1:0]   status;
        logic              fired;
        logic              en;
        logic              again;
        logic [31:0]       lagged;
        logic              last;
    } t_res;

    function automatic logic has_runs(input logic [RUNS_W-1:0] r);
        return (r == RUNS_FOREVER) || (r != '0 && r <= RUNS_MAX);
    endfunction

endpackage

/* src/periodic_task_timer_table.sv */
// Channel | Direction | tdata (low bit up)                              | tuser | tlast
// s_axis  | in        | req_type, slot, period, run_count, auto_clear,  | -     | -
//         |           | elapsed_ticks, delay_ticks                      |       |
// m_axis  | out       | out_slot, status, fired, enabled_now,           | -     | last
//         |           | runs_again, lagged_total                        |       |
// A non-service request is loaded on acceptance; its result is registered in S_CMD once the
// result port is free. A service request with nonzero ticks walks all slots twice, one slot a
// cycle while no firing waits on a stalled result port; zero ticks go straight to S_EMIT.
// Reset clears the valid, enable and pending flags and the lag counter.
// A stalled result holds the walk; no new request is taken until the last result is stored.
module periodic_task_timer_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // req_type, slot, period, run_count, auto_clear, elapsed_ticks, delay_ticks
    input  logic [pttt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_slot, status, fired, enabled_now, runs_again, lagged_total
    output logic [pttt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    pttt_pkg::t_cmd  cmd;
    pttt_pkg::t_stat stat;
    pttt_pkg::t_res  res;
    logic            out_free;
    logic            busy;
    logic            in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    pttt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_busy     (busy)
    );

    pttt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (s_axis_tdata[3:0]),
        .i_slot       (s_axis_tdata[7:4]),
        .i_period     (s_axis_tdata[39:8]),
        .i_run_count  (s_axis_tdata[55:40]),
        .i_auto_clear (s_axis_tdata[56]),
        .i_elapsed    (s_axis_tdata[88:57]),
        .i_delay      (s_axis_tdata[120:89]),
        .i_out_ready  (m_axis_tready),
        .o_stat       (stat),
        .o_out_free   (out_free),
        .o_out_valid  (m_axis_tvalid),
        .o_res        (res)
    );

    assign m_axis_tdata = {7'd0, res.lagged, res.again, res.en, res.fired,
                           res.status, res.slot};
    assign m_axis_tlast = res.last;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !busy)
        else $error("ready while busy");
    a_no_cmd_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.count && cmd.report))
        else $error("count and report together");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");

endmodule

/* src/pttt_ctrl.sv */
module pttt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_free,
    input  pttt_pkg::t_stat i_stat,
    output pttt_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_busy
);

    pttt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pttt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pttt_pkg::S_IDLE: begin
                if (i_in_fire) begin
                    n_state = pttt_pkg::S_CMD;
                end
            end
            pttt_pkg::S_CMD: begin
                if (!i_stat.is_service) begin
                    if (i_out_free) begin
                        n_state = pttt_pkg::S_IDLE;
                    end
                end else if (i_stat.zero_ticks) begin
                    n_state = pttt_pkg::S_EMIT;
                end else begin
                    n_state = pttt_pkg::S_COUNT;
                end
            end
            pttt_pkg::S_COUNT: begin
                if (i_stat.idx_last) begin
                    n_state = pttt_pkg::S_REPORT;
                end
            end
            pttt_pkg::S_REPORT: begin
                if (!i_stat.hit || i_out_free) begin
                    if (i_stat.idx_last) begin
                        n_state = i_stat.any_fired || (i_stat.hit) ?
                                  pttt_pkg::S_WAIT : pttt_pkg::S_EMIT;
                    end
                end
            end
            pttt_pkg::S_EMIT: begin
                if (i_out_free) begin
                    n_state = pttt_pkg::S_IDLE;
                end
            end
            pttt_pkg::S_WAIT: begin
                n_state = pttt_pkg::S_IDLE;
            end
            default: n_state = pttt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_busy     = 1'b1;
        unique case (r_state)
            pttt_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_busy       = 1'b0;
                o_cmd.load   = i_in_fire;
                o_cmd.clr_idx = 1'b1;
            end
            pttt_pkg::S_CMD: begin
                o_cmd.do_cmd = !i_stat.is_service && i_out_free;
            end
            pttt_pkg::S_COUNT: begin
                o_cmd.count    = 1'b1;
                o_cmd.step_idx = 1'b1;
            end
            pttt_pkg::S_REPORT: begin
                o_cmd.report   = !i_stat.hit || i_out_free;
                o_cmd.step_idx = !i_stat.hit || i_out_free;
            end
            pttt_pkg::S_EMIT: begin
                o_cmd.emit_none = i_out_free;
            end
            pttt_pkg::S_WAIT: begin
            end
            default: begin
            end
        endcase
    end

endmodule

/* src/pttt_dp.sv */
module pttt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pttt_pkg::t_cmd                i_cmd,
    input  logic [pttt_pkg::REQ_W-1:0]    i_req_type,
    input  logic [pttt_pkg::SLOT_W-1:0]   i_slot,
    input  logic [pttt_pkg::TICK_W-1:0]   i_period,
    input  logic [pttt_pkg::RUNS_W-1:0]   i_run_count,
    input  logic                          i_auto_clear,
    input  logic [pttt_pkg::TICK_W-1:0]   i_elapsed,
    input  logic [pttt_pkg::TICK_W-1:0]   i_delay,
    input  logic                          i_out_ready,
    output pttt_pkg::t_stat               o_stat,
    output logic                          o_out_free,
    output logic                          o_out_valid,
    output pttt_pkg::t_res                o_res
);

    localparam int S = pttt_pkg::SLOTS;
    localparam int SW = pttt_pkg::SLOT_W;
    localparam int TW = pttt_pkg::TICK_W;
    localparam int RW = pttt_pkg::RUNS_W;

    logic [S-1:0]  r_valid, r_en, r_pend;
    logic [S-1:0]  r_ac;
    logic [TW-1:0] r_per  [S];
    logic [TW-1:0] r_wait [S];
    logic [RW-1:0] r_runs [S];
    logic [31:0]   r_lag;

    logic [pttt_pkg::REQ_W-1:0] r_req;
    logic [SW-1:0] r_slot;
    logic [TW-1:0] r_period, r_elapsed, r_delay;
    logic [RW-1:0] r_rc;
    logic          r_acin;
    logic [SW-1:0] r_idx;
    logic          r_anyf;
    logic          r_ov;
    pttt_pkg::t_res r_res;

    logic          take;
    logic          hit;
    logic [SW-1:0] free_idx;
    logic          full;
    logic [TW-1:0] late;

    assign take       = o_out_valid && i_out_ready;
    assign o_out_free = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_res      = r_res;
    assign hit        = r_valid[r_idx] && r_pend[r_idx];
    assign late       = r_elapsed - r_wait[r_idx];

    assign o_stat.is_service = (r_req == pttt_pkg::REQ_SERVICE);
    assign o_stat.zero_ticks = (r_elapsed == '0);
    assign o_stat.idx_last   = (r_idx == SW'(S - 1));
    assign o_stat.hit        = hit;
    assign o_stat.any_fired  = r_anyf;

    always_comb begin
        free_idx = '0;
        full     = 1'b1;
        for (int k = S - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = SW'(k);
                full     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_slot    <= i_slot;
            r_period  <= i_period;
            r_rc      <= i_run_count;
            r_acin    <= i_auto_clear;
            r_elapsed <= i_elapsed;
            r_delay   <= i_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [RW-1:0] nr;
        logic          nv, ne;
        logic          bad;
        logic          ok;
        nr = r_runs[r_idx];
        nv = r_valid[r_idx];
        ne = r_en[r_idx];
        bad = 1'b0;
        ok = 1'b0;
        if (!i_rst_n) begin
            r_valid <= '0;
            r_en    <= '0;
            r_pend  <= '0;
            r_lag   <= '0;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_anyf  <= 1'b0;
        end else begin
            if (take) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.clr_idx) begin
                r_idx  <= '0;
                r_anyf <= 1'b0;
            end else if (i_cmd.step_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.count && r_valid[r_idx] && r_en[r_idx]) begin
                if (r_wait[r_idx] > r_elapsed) begin
                    r_wait[r_idx] <= r_wait[r_idx] - r_elapsed;
                end else begin
                    r_pend[r_idx] <= 1'b1;
                    if (late <= r_per[r_idx]) begin
                        r_wait[r_idx] <= r_per[r_idx] - late;
                    end else begin
                        r_wait[r_idx] <= r_per[r_idx];
                        r_lag         <= r_lag + 1'b1;
                    end
                end
            end
            if (i_cmd.report && hit) begin
                r_pend[r_idx] <= 1'b0;
                if (r_runs[r_idx] == pttt_pkg::RUNS_FOREVER) begin
                end else if (r_runs[r_idx] == '0) begin
                    ne = 1'b0;
                    r_en[r_idx] <= 1'b0;
                    if (r_ac[r_idx]) begin
                        nv = 1'b0;
                        r_valid[r_idx] <= 1'b0;
                    end else begin
                        r_wait[r_idx] <= r_per[r_idx];
                    end
                end else begin
                    nr = r_runs[r_idx] - 1'b1;
                    r_runs[r_idx] <= nr;
                end
                r_anyf       <= 1'b1;
                r_ov         <= 1'b1;
                r_res.slot   <= r_idx;
                r_res.status <= pttt_pkg::ST_OK;
                r_res.fired  <= 1'b1;
                r_res.en     <= nv && ne;
                r_res.again  <= nv && ne && pttt_pkg::has_runs(nr);
                r_res.lagged <= r_lag;
                r_res.last   <= (r_idx == SW'(S - 1)) || ((r_pend & r_valid) >>
                                (r_idx + 1'b1)) == '0;
            end
            if (i_cmd.emit_none) begin
                r_ov   <= 1'b1;
                r_res  <= '0;
                r_res.lagged <= r_lag;
                r_res.last   <= 1'b1;
            end
            if (i_cmd.do_cmd) begin
                r_res.slot   <= r_slot;
                r_res.status <= pttt_pkg::ST_OK;
                r_res.fired  <= 1'b0;
                r_res.lagged <= r_lag;
                r_res.last   <= 1'b1;
                r_res.en     <= 1'b0;
                r_res.again  <= 1'b0;
                r_ov         <= 1'b1;
                if (r_req == pttt_pkg::REQ_CREATE) begin
                    r_res.slot <= '0;
                    if (r_period <= TW'(1)) begin
                        r_res.status <= pttt_pkg::ST_BAD;
                    end else if (full) begin
                        r_res.status <= pttt_pkg::ST_FULL;
                    end else begin
                        r_valid[free_idx] <= 1'b1;
                        r_en[free_idx]    <= 1'b1;
                        r_pend[free_idx]  <= 1'b0;
                        r_ac[free_idx]    <= r_acin;
                        r_per[free_idx]   <= r_period;
                        r_wait[free_idx]  <= r_period;
                        r_runs[free_idx]  <= r_rc;
                        r_res.slot  <= free_idx;
                        r_res.en    <= 1'b1;
                        r_res.again <= pttt_pkg::has_runs(r_rc);
                    end
                end else begin
                    bad = (r_req > pttt_pkg::REQ_RESTART) || !r_valid[r_slot] ||
                          ((r_req == pttt_pkg::REQ_ALTER || r_req == pttt_pkg::REQ_PERIOD)
                           && r_period <= TW'(1));
                    ok = (r_req <= pttt_pkg::REQ_RESTART) && r_valid[r_slot];
                    nr = r_runs[r_slot];
                    ne = r_en[r_slot];
                    if (bad) begin
                        r_res.status <= pttt_pkg::ST_BAD;
                    end else begin
                        unique case (r_req)
                            pttt_pkg::REQ_ALTER: begin
                                r_pend[r_slot] <= 1'b0;
                                r_runs[r_slot] <= r_rc;
                                r_per[r_slot]  <= r_period;
                                r_wait[r_slot] <= r_period;
                                r_ac[r_slot]   <= r_acin;
                                nr = r_rc;
                            end
                            pttt_pkg::REQ_PERIOD: begin
                                r_pend[r_slot] <= 1'b0;
                                r_per[r_slot]  <= r_period;
                                r_wait[r_slot] <= r_period;
                            end
                            pttt_pkg::REQ_RUNS: begin
                                r_pend[r_slot] <= 1'b0;
                                r_runs[r_slot] <= r_rc;
                                nr = r_rc;
                            end
                            pttt_pkg::REQ_AUTOCLEAR: r_ac[r_slot] <= r_acin;
                            pttt_pkg::REQ_ENABLE: begin
                                r_en[r_slot] <= 1'b1;
                                ne = 1'b1;
                            end
                            pttt_pkg::REQ_DISABLE: begin
                                r_en[r_slot]   <= 1'b0;
                                r_pend[r_slot] <= 1'b0;
                                r_wait[r_slot] <= r_per[r_slot];
                                ne = 1'b0;
                            end
                            pttt_pkg::REQ_DELAY: begin
                                r_wait[r_slot] <= r_delay;
                                r_en[r_slot]   <= 1'b1;
                                ne = 1'b1;
                            end
                            pttt_pkg::REQ_FIRE: begin
                                r_pend[r_slot] <= 1'b1;
                                r_wait[r_slot] <= r_per[r_slot];
                            end
                            pttt_pkg::REQ_REMOVE: begin
                                r_valid[r_slot] <= 1'b0;
                                r_en[r_slot]    <= 1'b0;
                                r_pend[r_slot]  <= 1'b0;
                                ok = 1'b0;
                            end
                            pttt_pkg::REQ_RESTART: begin
                                r_wait[r_slot] <= r_per[r_slot];
                                r_en[r_slot]   <= 1'b1;
                                ne = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                    r_res.en    <= ok && ne;
                    r_res.again <= ok && ne && pttt_pkg::has_runs(nr);
                end
            end
        end
    end

endmodule

/* tb/pttt_checker.sv */
`timescale 1ns / 1ps

module pttt_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [pttt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [pttt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             m_axis_tlast,
    output int                               o_errors,
    output int                               o_outstanding
);

    logic                        t_valid [pttt_pkg::SLOTS];
    logic                        t_en    [pttt_pkg::SLOTS];
    logic                        t_pend  [pttt_pkg::SLOTS];
    logic                        t_ac    [pttt_pkg::SLOTS];
    logic [pttt_pkg::TICK_W-1:0] t_per   [pttt_pkg::SLOTS];
    logic [pttt_pkg::TICK_W-1:0] t_wait  [pttt_pkg::SLOTS];
    logic [pttt_pkg::RUNS_W-1:0] t_runs  [pttt_pkg::SLOTS];
    logic [31:0]                 lags;
    pttt_pkg::t_res              exp_results[$];

    assign o_outstanding = exp_results.size();

    function automatic logic runs_left(input logic [pttt_pkg::RUNS_W-1:0] r);
        return (r == pttt_pkg::RUNS_FOREVER) || (r != '0 && !r[pttt_pkg::RUNS_W-1]);
    endfunction

    task automatic push_result(input logic [pttt_pkg::SLOT_W-1:0] sl,
                               input logic [pttt_pkg::ST_W-1:0] st,
                               input logic fi, input logic en, input logic ag,
                               input logic lst);
        pttt_pkg::t_res r;
        r.slot = sl;
        r.status = st;
        r.fired = fi;
        r.en = en;
        r.again = ag;
        r.lagged = lags;
        r.last = lst;
        exp_results.push_back(r);
    endtask

    task automatic run_service(input logic [pttt_pkg::TICK_W-1:0] ticks);
        logic [pttt_pkg::TICK_W-1:0] late;
        int n;
        logic en;
        n = 0;
        if (ticks == '0) begin
            push_result('0, pttt_pkg::ST_OK, 1'b0, 1'b0, 1'b0, 1'b1);
            return;
        end
        for (int s = 0; s < pttt_pkg::SLOTS; s++) begin
            if (t_valid[s] && t_en[s]) begin
                if (t_wait[s] > ticks) begin
                    t_wait[s] = t_wait[s] - ticks;
                end else begin
                    late = ticks - t_wait[s];
                    t_pend[s] = 1'b1;
                    if (late <= t_per[s]) begin
                        t_wait[s] = t_per[s] - late;
                    end else begin
                        t_wait[s] = t_per[s];
                        lags = lags + 1;
                    end
                end
            end
        end
        for (int s = 0; s < pttt_pkg::SLOTS; s++) begin
            if (t_valid[s] && t_pend[s]) begin
                t_pend[s] = 1'b0;
                if (t_runs[s] == pttt_pkg::RUNS_FOREVER) begin
                end else if (t_runs[s] == '0) begin
                    t_en[s] = 1'b0;
                    if (t_ac[s]) begin
                        t_valid[s] = 1'b0;
                    end else begin
                        t_wait[s] = t_per[s];
                    end
                end else begin
                    t_runs[s] = t_runs[s] - 1'b1;
                end
                en = t_valid[s] && t_en[s];
                push_result(pttt_pkg::SLOT_W'(s), pttt_pkg::ST_OK, 1'b1, en,
                            en && runs_left(t_runs[s]), 1'b0);
                n++;
            end
        end
        if (n == 0) begin
            push_result('0, pttt_pkg::ST_OK, 1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
            exp_results[$].last = 1'b1;
        end
    endtask

    task automatic predict_request(input logic [pttt_pkg::IN_TDATA_W-1:0] d);
        logic [pttt_pkg::REQ_W-1:0]  req;
        logic [pttt_pkg::SLOT_W-1:0] sf;
        logic [pttt_pkg::TICK_W-1:0] per;
        logic [pttt_pkg::RUNS_W-1:0] runs;
        logic                        ac;
        logic [pttt_pkg::TICK_W-1:0] dly;
        logic [pttt_pkg::ST_W-1:0]   st;
        logic [pttt_pkg::SLOT_W-1:0] osl;
        logic                        ok;
        int                          s;
        int                          f;
        logic                        en;
        req  = d[3:0];
        sf   = d[7:4];
        per  = d[39:8];
        runs = d[55:40];
        ac   = d[56];
        dly  = d[120:89];
        st   = pttt_pkg::ST_OK;
        osl  = sf;
        s    = sf;
        ok   = t_valid[s];
        if (req == pttt_pkg::REQ_SERVICE) begin
            run_service(d[88:57]);
            return;
        end
        if (req == pttt_pkg::REQ_CREATE) begin
            osl = '0;
            ok = 1'b0;
            if (per <= 1) begin
                st = pttt_pkg::ST_BAD;
            end else begin
                f = 0;
                while (f < pttt_pkg::SLOTS && t_valid[f]) f++;
                if (f >= pttt_pkg::SLOTS) begin
                    st = pttt_pkg::ST_FULL;
                end else begin
                    t_valid[f] = 1'b1;
                    t_en[f]    = 1'b1;
                    t_pend[f]  = 1'b0;
                    t_ac[f]    = ac;
                    t_per[f]   = per;
                    t_wait[f]  = per;
                    t_runs[f]  = runs;
                    osl = pttt_pkg::SLOT_W'(f);
                    s = f;
                    ok = 1'b1;
                end
            end
        end else if (req > pttt_pkg::REQ_RESTART || !ok) begin
            st = pttt_pkg::ST_BAD;
            ok = 1'b0;
        end else if ((req == pttt_pkg::REQ_ALTER || req == pttt_pkg::REQ_PERIOD) && per <= 1)
        begin
            st = pttt_pkg::ST_BAD;
        end else begin
            case (req)
                pttt_pkg::REQ_ALTER: begin
                    t_pend[s] = 1'b0;
                    t_runs[s] = runs;
                    t_per[s]  = per;
                    t_wait[s] = per;
                    t_ac[s]   = ac;
                end
                pttt_pkg::REQ_PERIOD: begin
                    t_pend[s] = 1'b0;
                    t_per[s]  = per;
                    t_wait[s] = per;
                end
                pttt_pkg::REQ_RUNS: begin
                    t_pend[s] = 1'b0;
                    t_runs[s] = runs;
                end
                pttt_pkg::REQ_AUTOCLEAR: t_ac[s] = ac;
                pttt_pkg::REQ_ENABLE:    t_en[s] = 1'b1;
                pttt_pkg::REQ_DISABLE: begin
                    t_en[s]   = 1'b0;
                    t_pend[s] = 1'b0;
                    t_wait[s] = t_per[s];
                end
                pttt_pkg::REQ_DELAY: begin
                    t_wait[s] = dly;
                    t_en[s]   = 1'b1;
                end
                pttt_pkg::REQ_FIRE: begin
                    t_pend[s] = 1'b1;
                    t_wait[s] = t_per[s];
                end
                pttt_pkg::REQ_REMOVE: begin
                    t_valid[s] = 1'b0;
                    t_en[s]    = 1'b0;
                    t_pend[s]  = 1'b0;
                    ok = 1'b0;
                end
                pttt_pkg::REQ_RESTART: begin
                    t_wait[s] = t_per[s];
                    t_en[s]   = 1'b1;
                end
                default: ;
            endcase
        end
        en = ok && t_valid[s] && t_en[s];
        push_result(osl, st, 1'b0, en, en && runs_left(t_runs[s]), 1'b1);
    endtask

    always @(posedge i_clk) begin
        pttt_pkg::t_res got;
        pttt_pkg::t_res want;
        if (!i_rst_n) begin
            for (int s = 0; s < pttt_pkg::SLOTS; s++) begin
                t_valid[s] = 1'b0;
                t_en[s]    = 1'b0;
                t_pend[s]  = 1'b0;
            end
            lags = '0;
            exp_results.delete();
            o_errors <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot   = m_axis_tdata[3:0];
                got.status = m_axis_tdata[5:4];
                got.fired  = m_axis_tdata[6];
                got.en     = m_axis_tdata[7];
                got.again  = m_axis_tdata[8];
                got.lagged = m_axis_tdata[40:9];
                got.last   = m_axis_tlast;
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = exp_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(s_axis_tdata);
            end
        end
    end

endmodule

/* tb/tb_periodic_task_timer_table.sv */
`timescale 1ns / 1ps

module tb_periodic_task_timer_table;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [pttt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [pttt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    int                               errors;
    int                               outstanding;
    logic                             calm;
    int                               idle_cycles;
    int                               stall_left;

    periodic_task_timer_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    pttt_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [pttt_pkg::IN_TDATA_W-1:0] pack_request(
        input logic [pttt_pkg::REQ_W-1:0] req, input logic [pttt_pkg::SLOT_W-1:0] sl,
        input logic [31:0] per, input logic [15:0] runs, input logic ac,
        input logic [31:0] ticks, input logic [31:0] dly);
        logic [pttt_pkg::IN_TDATA_W-1:0] d;
        d = '0;
        d[3:0]    = req;
        d[7:4]    = sl;
        d[39:8]   = per;
        d[55:40]  = runs;
        d[56]     = ac;
        d[88:57]  = ticks;
        d[120:89] = dly;
        return d;
    endfunction

    task automatic send(input logic [pttt_pkg::IN_TDATA_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [pttt_pkg::REQ_W-1:0] req;
        logic [31:0] per;
        logic [31:0] ticks;
        logic [31:0] dly;
        logic [15:0] runs;
        logic [pttt_pkg::SLOT_W-1:0] sl;
        req   = ($urandom_range(0, 2) == 0) ? pttt_pkg::REQ_SERVICE :
                pttt_pkg::REQ_W'($urandom_range(0, 15));
        sl    = ($urandom_range(0, 4) == 0) ? pttt_pkg::SLOT_W'($urandom) :
                pttt_pkg::SLOT_W'($urandom_range(0, 5));
        per   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        ticks = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
        dly   = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 50);
        runs  = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                16'($signed($urandom_range(0, 6)) - 1);
        if ($urandom_range(0, 5) == 0) req = pttt_pkg::REQ_CREATE;
        send(pack_request(req, sl, per, runs, 1'($urandom), ticks, dly));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            m_axis_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 3000) begin
                $display("[periodic_task_timer_table] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        idle_cycles   = 0;
        stall_left    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(pack_request(pttt_pkg::REQ_SERVICE, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_QUERY, 4'd0, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_CREATE, 4'd0, 32'd1, 16'd3, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_CREATE, 4'd0, 32'd0, 16'd3, 1'b0, 32'd0, 32'd0));
        for (int i = 0; i < pttt_pkg::SLOTS + 1; i++) begin
            send(pack_request(pttt_pkg::REQ_CREATE, 4'd15, 32'd2 + i,
                              (i == 3) ? 16'hFFFE :
                              (i == 4) ? 16'h7FFF : 16'($signed(i % 3) - 1),
                              i[0], 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        end
        send(pack_request(pttt_pkg::REQ_SERVICE, 4'd0, 32'd0, 16'd0, 1'b0, 32'd1000, 32'd0));
        send(pack_request(pttt_pkg::REQ_FIRE, 4'd5, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_DISABLE, 4'd5, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_FIRE, 4'd6, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_DISABLE, 4'd6, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_FIRE, 4'd6, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(pttt_pkg::REQ_SERVICE, 4'd0, 32'd0, 16'd0, 1'b0,
                          32'hFFFF_FFFF, 32'd0));
        send(pack_request(4'd13, 4'd1, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));
        send(pack_request(4'd15, 4'd15, 32'd0, 16'd0, 1'b0, 32'd0, 32'd0));

        for (int i = 0; i < 120; i++) begin
            if (i == 95) calm = 1'b1;
            send_random();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("[periodic_task_timer_table] OK");
        end else begin
            $display("[periodic_task_timer_table] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/pttt_pkg.sv
src/pttt_ctrl.sv
src/pttt_dp.sv
src/periodic_task_timer_table.sv
tb/pttt_checker.sv
tb/tb_periodic_task_timer_table.sv
